>>> design/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define PRR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define PRR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/prr_pkg.sv
// package: widths, register indexes, payload types and rounding helpers
package prr_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int PHASOR_FRAC_BITS = 16;
    localparam int PHASOR_BITS      = PHASOR_FRAC_BITS + 2;
    localparam int CFG_IDX_BITS     = 3;
    localparam int CFG_DATA_BITS    = PHASOR_BITS;
    localparam int QUEUE_DEPTH      = 4;

    localparam int PROD_S_W = SAMPLE_BITS + PHASOR_BITS;
    localparam int SUM_S_W  = PROD_S_W + 1;
    localparam int PROD_P_W = 2 * PHASOR_BITS;
    localparam int SUM_P_W  = PROD_P_W + 1;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_START_COS  = 3'd0,
        CFG_START_SIN  = 3'd1,
        CFG_STEP_COS   = 3'd2,
        CFG_STEP_SIN   = 3'd3,
        CFG_HYPER_MODE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] first_real;
        logic signed [SAMPLE_BITS-1:0] first_imag;
        logic signed [SAMPLE_BITS-1:0] second_real;
        logic signed [SAMPLE_BITS-1:0] second_imag;
        logic                          last_point;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] rot_first_real;
        logic signed [SAMPLE_BITS-1:0] rot_first_imag;
        logic signed [SAMPLE_BITS-1:0] rot_second_real;
        logic signed [SAMPLE_BITS-1:0] rot_second_imag;
        logic                          last_out;
    } t_out_item;

    typedef struct packed {
        t_in_item                      item;
        logic                          hyper;
        logic signed [PHASOR_BITS-1:0] cos_v;
        logic signed [PHASOR_BITS-1:0] sin_v;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // round half up after dropping the fraction, then saturate to sample width
    function automatic logic signed [SAMPLE_BITS-1:0] rnd_sat_sample(
        input logic signed [SUM_S_W-1:0] sum
    );
        logic signed [SUM_S_W:0]                  biased;
        logic signed [SUM_S_W-PHASOR_FRAC_BITS:0] q;
        logic signed [SAMPLE_BITS-1:0]            r;
        biased = (SUM_S_W+1)'(sum) + $signed({{(SUM_S_W+1-PHASOR_FRAC_BITS){1'b0}}, 1'b1,
                                              {(PHASOR_FRAC_BITS-1){1'b0}}});
        q = $signed(biased[SUM_S_W:PHASOR_FRAC_BITS]);
        if (q > $signed({{(SUM_S_W-PHASOR_FRAC_BITS-SAMPLE_BITS+2){1'b0}},
                         {(SAMPLE_BITS-1){1'b1}}})) begin
            r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end else if (q < $signed({{(SUM_S_W-PHASOR_FRAC_BITS-SAMPLE_BITS+2){1'b1}},
                                  {(SAMPLE_BITS-1){1'b0}}})) begin
            r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            r = q[SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    // same rounding, saturated to phasor width
    function automatic logic signed [PHASOR_BITS-1:0] rnd_sat_phasor(
        input logic signed [SUM_P_W-1:0] sum
    );
        logic signed [SUM_P_W:0]                  biased;
        logic signed [SUM_P_W-PHASOR_FRAC_BITS:0] q;
        logic signed [PHASOR_BITS-1:0]            r;
        biased = (SUM_P_W+1)'(sum) + $signed({{(SUM_P_W+1-PHASOR_FRAC_BITS){1'b0}}, 1'b1,
                                              {(PHASOR_FRAC_BITS-1){1'b0}}});
        q = $signed(biased[SUM_P_W:PHASOR_FRAC_BITS]);
        if (q > $signed({{(SUM_P_W-PHASOR_FRAC_BITS-PHASOR_BITS+2){1'b0}},
                         {(PHASOR_BITS-1){1'b1}}})) begin
            r = {1'b0, {(PHASOR_BITS-1){1'b1}}};
        end else if (q < $signed({{(SUM_P_W-PHASOR_FRAC_BITS-PHASOR_BITS+2){1'b1}},
                                  {(PHASOR_BITS-1){1'b0}}})) begin
            r = {1'b1, {(PHASOR_BITS-1){1'b0}}};
        end else begin
            r = q[PHASOR_BITS-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/phase_ramp_rotator_top.sv
// top level: phase ramp rotator with recursive phasor
// Takes one sample beat per clock while the queue is not full and returns one result
// beat per sample, in order. The front end computes the phasor for each sample as it
// is taken (four 18x18 multiplies and two adds per sample close the recurrence) and
// drops the sample with its phasor into a QUEUE_DEPTH-entry queue. The back end pops
// the queue into a two-stage pipeline (products, then sum with round-half-up and
// saturation to 24 bits); a result passes the queue, the product registers and the
// result register. Sustained rate is one sample per cycle while results are popped.
// Register writes belong to idle periods; start values apply at the next vector.
module phase_ramp_rotator_top #(
    parameter int QUEUE_DEPTH = prr_pkg::QUEUE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  prr_pkg::t_in_item                   i_item,
    output logic                                empty,
    input  logic                                pop,
    output prr_pkg::t_out_item                  o_result,
    input  logic                                i_cfg_wr_en,
    input  logic [prr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [prr_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);
    import prr_pkg::*;

    `include "assert_macros.svh"

    logic    q_push, q_pop;
    t_job    q_in_job, q_out_job;
    t_q_stat q_stat;

    prr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_q_full    (q_stat.full),
        .o_q_push    (q_push),
        .o_job       (q_in_job),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    prr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_stat  (q_stat)
    );

    prr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_stat.empty),
        .i_job     (q_out_job),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (o_result)
    );

    assign full = q_stat.full;

    `PRR_ASSERT_ALWAYS(a_q_status, !(q_stat.full && q_stat.empty), "queue full and empty")
    `PRR_ASSERT_ALWAYS(a_pop_nonempty, !(q_pop && q_stat.empty), "back end pops empty queue")
    `PRR_ASSERT_NEXT(a_push_lands, push && !full, !q_stat.empty, "accepted beat lost")

endmodule

>>> design/prr_front.sv
// front end: config registers, phasor recurrence, job issue into the queue
module prr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  prr_pkg::t_in_item                   i_item,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output prr_pkg::t_job                       o_job,
    input  logic                                i_cfg_wr_en,
    input  logic [prr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [prr_pkg::CFG_DATA_BITS-1:0]   i_cfg_wdata
);
    import prr_pkg::*;

    logic signed [PHASOR_BITS-1:0] r_start_cos, r_start_sin;
    logic signed [PHASOR_BITS-1:0] r_step_cos, r_step_sin;
    logic                          r_hyper;
    logic signed [PHASOR_BITS-1:0] r_ph_cos, r_ph_sin;
    logic                          r_at_start;

    logic signed [PHASOR_BITS-1:0] cur_cos, cur_sin;
    logic signed [PHASOR_BITS-1:0] n_ph_cos, n_ph_sin;
    logic signed [PROD_P_W-1:0]    p_cc, p_ss, p_sc, p_cs;
    logic                          accept;
    logic                          step_nz;

    assign accept  = i_push && !i_q_full;
    assign cur_cos = r_at_start ? r_start_cos : r_ph_cos;
    assign cur_sin = r_at_start ? r_start_sin : r_ph_sin;
    assign step_nz = (r_step_cos != '0) || (r_step_sin != '0);

    assign p_cc = cur_cos * r_step_cos;
    assign p_ss = cur_sin * r_step_sin;
    assign p_sc = cur_sin * r_step_cos;
    assign p_cs = cur_cos * r_step_sin;

    always_comb begin
        n_ph_cos = rnd_sat_phasor(SUM_P_W'(p_cc) - SUM_P_W'(p_ss));
        n_ph_sin = rnd_sat_phasor(SUM_P_W'(p_sc) + SUM_P_W'(p_cs));
    end

    assign o_q_push    = accept;
    assign o_job.item  = i_item;
    assign o_job.hyper = r_hyper;
    assign o_job.cos_v = cur_cos;
    assign o_job.sin_v = cur_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_cos <= PHASOR_BITS'(1 <<< PHASOR_FRAC_BITS);
            r_start_sin <= '0;
            r_step_cos  <= PHASOR_BITS'(1 <<< PHASOR_FRAC_BITS);
            r_step_sin  <= '0;
            r_hyper     <= 1'b0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_START_COS:  r_start_cos <= $signed(i_cfg_wdata);
                CFG_START_SIN:  r_start_sin <= $signed(i_cfg_wdata);
                CFG_STEP_COS:   r_step_cos  <= $signed(i_cfg_wdata);
                CFG_STEP_SIN:   r_step_sin  <= $signed(i_cfg_wdata);
                CFG_HYPER_MODE: r_hyper     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_cos   <= '0;
            r_ph_sin   <= '0;
            r_at_start <= 1'b1;
        end else if (accept) begin
            if (i_item.last_point) begin
                r_at_start <= 1'b1;
            end else begin
                r_at_start <= 1'b0;
                r_ph_cos   <= step_nz ? n_ph_cos : cur_cos;
                r_ph_sin   <= step_nz ? n_ph_sin : cur_sin;
            end
        end
    end

endmodule

>>> design/prr_queue.sv
// job queue between front end and rotation pipeline
module prr_queue #(
    parameter int DEPTH = prr_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  prr_pkg::t_job     i_job,
    input  logic              i_pop,
    output prr_pkg::t_job     o_job,
    output prr_pkg::t_q_stat  o_stat
);
    import prr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> design/prr_back.sv
// back end: two-stage rotation pipeline, multiply then round and saturate
module prr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  prr_pkg::t_job      i_job,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output prr_pkg::t_out_item o_result
);
    import prr_pkg::*;

    logic                       r_v1, r_v2;
    logic signed [PROD_S_W-1:0] r_p_frc, r_p_fis, r_p_fic, r_p_frs;
    logic signed [PROD_S_W-1:0] r_p_src, r_p_sis, r_p_sic, r_p_srs;
    logic                       r_last1, r_hyper1;
    t_out_item                  r_res;
    t_out_item                  n_res;
    logic                       ready1, ready2;

    assign ready2   = !r_v2 || i_pop;
    assign ready1   = !r_v1 || ready2;
    assign o_q_pop  = ready1 && !i_q_empty;
    assign o_empty  = !r_v2;
    assign o_result = r_res;

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_p_frc  <= i_job.item.first_real  * i_job.cos_v;
            r_p_fis  <= i_job.item.first_imag  * i_job.sin_v;
            r_p_fic  <= i_job.item.first_imag  * i_job.cos_v;
            r_p_frs  <= i_job.item.first_real  * i_job.sin_v;
            r_p_src  <= i_job.item.second_real * i_job.cos_v;
            r_p_sis  <= i_job.item.second_imag * i_job.sin_v;
            r_p_sic  <= i_job.item.second_imag * i_job.cos_v;
            r_p_srs  <= i_job.item.second_real * i_job.sin_v;
            r_last1  <= i_job.item.last_point;
            r_hyper1 <= i_job.hyper;
        end
    end

    // stage 2: sums, rounding, saturation
    always_comb begin
        n_res.rot_first_real = rnd_sat_sample(SUM_S_W'(r_p_frc) + SUM_S_W'(r_p_fis));
        n_res.rot_first_imag = rnd_sat_sample(SUM_S_W'(r_p_fic) - SUM_S_W'(r_p_frs));
        if (r_hyper1) begin
            n_res.rot_second_real = rnd_sat_sample(SUM_S_W'(r_p_src) + SUM_S_W'(r_p_sis));
            n_res.rot_second_imag = rnd_sat_sample(SUM_S_W'(r_p_sic) - SUM_S_W'(r_p_srs));
        end else begin
            n_res.rot_second_real = '0;
            n_res.rot_second_imag = '0;
        end
        n_res.last_out = r_last1;
    end

    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_v1 <= 1'b1;
            end else if (ready2) begin
                r_v1 <= 1'b0;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

endmodule

>>> bench/tb_phase_ramp_rotator_top.sv
// testbench for phase_ramp_rotator_top: random and corner beats checked against a phasor predictor
module tb_phase_ramp_rotator_top;
    import prr_pkg::*;

    localparam longint S_MAX       = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint S_MIN       = -(longint'(1) << (SAMPLE_BITS - 1));
    localparam longint P_MAX       = (longint'(1) << (PHASOR_BITS - 1)) - 1;
    localparam longint P_MIN       = -(longint'(1) << (PHASOR_BITS - 1));
    localparam longint P_ONE       = longint'(1) << PHASOR_FRAC_BITS;
    localparam int     HOLD_CYCLES = 300;
    localparam int     STALL_LIMIT = 5000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    t_in_item                 i_item = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    t_out_item                o_result;
    logic                     i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_wdata = '0;

    // predictor copy of the registers and phasor state
    logic signed [PHASOR_BITS-1:0] cfg_start_cos = PHASOR_BITS'(P_ONE);
    logic signed [PHASOR_BITS-1:0] cfg_start_sin = '0;
    logic signed [PHASOR_BITS-1:0] cfg_step_cos = PHASOR_BITS'(P_ONE);
    logic signed [PHASOR_BITS-1:0] cfg_step_sin = '0;
    logic                          cfg_hyper = 1'b0;
    logic signed [PHASOR_BITS-1:0] ph_cos = '0;
    logic signed [PHASOR_BITS-1:0] ph_sin = '0;
    logic                          vector_start = 1'b1;

    t_out_item expected_rotations[$];
    int        mismatches = 0;
    int        beats_checked = 0;
    int        idle_pct = 37;
    int        hold_requests = 0;
    int        hold_served = 0;
    int        hold_left = 0;
    int        stall_count = 0;

    phase_ramp_rotator_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // drop the fraction with round half up, then clamp to w signed bits
    function automatic longint round_sat(longint sum, int w);
        longint r;
        longint hi;
        longint lo;
        r  = (sum + (longint'(1) << (PHASOR_FRAC_BITS - 1))) >>> PHASOR_FRAC_BITS;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -(longint'(1) << (w - 1));
        if (r > hi) return hi;
        if (r < lo) return lo;
        return r;
    endfunction

    function automatic t_out_item rotate_sample(t_in_item it);
        t_out_item r;
        longint    fr;
        longint    fi;
        longint    sr;
        longint    si;
        longint    c;
        longint    s;
        longint    tc;
        longint    ts;
        if (vector_start) begin
            ph_cos       = cfg_start_cos;
            ph_sin       = cfg_start_sin;
            vector_start = 1'b0;
        end
        c  = ph_cos;
        s  = ph_sin;
        tc = cfg_step_cos;
        ts = cfg_step_sin;
        fr = it.first_real;
        fi = it.first_imag;
        sr = it.second_real;
        si = it.second_imag;
        r.rot_first_real = SAMPLE_BITS'(round_sat(fr * c + fi * s, SAMPLE_BITS));
        r.rot_first_imag = SAMPLE_BITS'(round_sat(fi * c - fr * s, SAMPLE_BITS));
        if (cfg_hyper) begin
            r.rot_second_real = SAMPLE_BITS'(round_sat(sr * c + si * s, SAMPLE_BITS));
            r.rot_second_imag = SAMPLE_BITS'(round_sat(si * c - sr * s, SAMPLE_BITS));
        end else begin
            r.rot_second_real = '0;
            r.rot_second_imag = '0;
        end
        r.last_out = it.last_point;
        if (it.last_point) begin
            vector_start = 1'b1;
        end else if (tc != 0 || ts != 0) begin
            ph_cos = PHASOR_BITS'(round_sat(c * tc - s * ts, PHASOR_BITS));
            ph_sin = PHASOR_BITS'(round_sat(s * tc + c * ts, PHASOR_BITS));
        end
        return r;
    endfunction

    function automatic t_in_item make_sample(longint fr, longint fi, longint sr, longint si,
                                             logic last);
        t_in_item it;
        it.first_real  = fr[SAMPLE_BITS-1:0];
        it.first_imag  = fi[SAMPLE_BITS-1:0];
        it.second_real = sr[SAMPLE_BITS-1:0];
        it.second_imag = si[SAMPLE_BITS-1:0];
        it.last_point  = last;
        return it;
    endfunction

    function automatic longint pick_value();
        case ($urandom_range(7))
            0: return S_MAX;
            1: return S_MIN;
            2: return longint'($urandom_range(0, 200)) - 100;
            default: return longint'($urandom);
        endcase
    endfunction

    function automatic t_in_item random_sample(logic last);
        return make_sample(pick_value(), pick_value(), pick_value(), pick_value(), last);
    endfunction

    function automatic longint pick_phasor();
        case ($urandom_range(4))
            0: return P_MAX;
            1: return P_MIN;
            default: return longint'($urandom);
        endcase
    endfunction

    task automatic pick_pair(output longint c, output longint s);
        real ang;
        ang = real'($urandom_range(0, 3599)) * 3.141592653589793 / 1800.0;
        case ($urandom_range(7))
            0, 1: begin
                c = pick_phasor();
                s = pick_phasor();
            end
            2: begin
                c = 0;
                s = 0;
            end
            default: begin
                c = $rtoi($cos(ang) * 65535.0);
                s = $rtoi($sin(ang) * 65535.0);
            end
        endcase
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        mismatches++;
        $display("error: beat %0d %s got %0d expected %0d", beats_checked, what, got, want);
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_rotations.size() == 0) begin
            report_mismatch("result with nothing pending", got.rot_first_real, 0);
        end else begin
            want = expected_rotations.pop_front();
            if (got.rot_first_real !== want.rot_first_real)
                report_mismatch("rot_first_real", got.rot_first_real, want.rot_first_real);
            if (got.rot_first_imag !== want.rot_first_imag)
                report_mismatch("rot_first_imag", got.rot_first_imag, want.rot_first_imag);
            if (got.rot_second_real !== want.rot_second_real)
                report_mismatch("rot_second_real", got.rot_second_real, want.rot_second_real);
            if (got.rot_second_imag !== want.rot_second_imag)
                report_mismatch("rot_second_imag", got.rot_second_imag, want.rot_second_imag);
            if (got.last_out !== want.last_out)
                report_mismatch("last_out", got.last_out, want.last_out);
        end
        beats_checked++;
    endtask

    // result side: random pop, long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) check_result(o_result);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) stall_count = 0;
        else stall_count++;
        if (stall_count >= STALL_LIMIT) begin
            $display("phase_ramp_rotator_top: mismatch");
            $finish;
        end
    end

    task automatic send_sample(t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        expected_rotations.push_back(rotate_sample(it));
    endtask

    task automatic wait_all_results();
        push <= 1'b0;
        while (expected_rotations.size() != 0) @(posedge i_clk);
    endtask

    task automatic load_setup(longint sc, longint ss, longint tc, longint ts, logic hm);
        t_cfg_idx                 order [5] = '{CFG_START_COS, CFG_START_SIN, CFG_STEP_COS,
                                                CFG_STEP_SIN, CFG_HYPER_MODE};
        logic [CFG_DATA_BITS-1:0] data [5];
        data[0] = sc[CFG_DATA_BITS-1:0];
        data[1] = ss[CFG_DATA_BITS-1:0];
        data[2] = tc[CFG_DATA_BITS-1:0];
        data[3] = ts[CFG_DATA_BITS-1:0];
        data[4] = {(CFG_DATA_BITS-1)'($urandom), hm};
        wait_all_results();
        repeat (4) @(posedge i_clk);
        for (int k = 0; k < 5; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_idx   <= order[k];
            i_cfg_wdata <= data[k];
            @(posedge i_clk);
        end
        i_cfg_wr_en   <= 1'b0;
        cfg_start_cos = sc[PHASOR_BITS-1:0];
        cfg_start_sin = ss[PHASOR_BITS-1:0];
        cfg_step_cos  = tc[PHASOR_BITS-1:0];
        cfg_step_sin  = ts[PHASOR_BITS-1:0];
        cfg_hyper     = hm;
    endtask

    task automatic load_random_setup();
        longint sc;
        longint ss;
        longint tc;
        longint ts;
        pick_pair(sc, ss);
        pick_pair(tc, ts);
        load_setup(sc, ss, tc, ts, 1'($urandom));
    endtask

    // vectors of random length; the last one may be cut short
    task automatic send_vectors(int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n) begin
            len = ($urandom_range(7) == 0) ? 1 : $urandom_range(2, 40);
            for (int i = 0; i < len && sent < n; i++) begin
                send_sample(random_sample(i == len - 1));
                sent++;
            end
        end
    endtask

    task automatic test_identity_after_reset();
        send_sample(make_sample(S_MAX, S_MAX, S_MAX, S_MAX, 1'b0));
        send_sample(make_sample(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0));
        send_sample(make_sample(1, -1, 5, -5, 1'b0));
        send_sample(make_sample(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1));
    endtask

    task automatic test_directed_corners();
        // quarter turn, frozen phasor, hypercomplex; imag of a negated min sample saturates high
        load_setup(0, P_ONE, 0, 0, 1'b1);
        send_sample(make_sample(S_MAX, S_MAX, S_MIN, S_MAX, 1'b0));
        send_sample(make_sample(S_MIN, S_MIN, S_MAX, S_MIN, 1'b0));
        send_sample(make_sample(S_MAX, S_MIN, 0, -1, 1'b1));
        // most negative start phasor and most positive steps: sample and phasor saturation, then reload
        load_setup(P_MIN, P_MIN, P_MAX, P_MAX, 1'b1);
        send_sample(make_sample(S_MAX, S_MAX, S_MIN, S_MIN, 1'b0));
        send_sample(make_sample(S_MIN, S_MAX, S_MAX, S_MIN, 1'b0));
        send_sample(make_sample(1000, -1000, 77, -77, 1'b0));
        send_sample(make_sample(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1));
        send_sample(make_sample(S_MAX, S_MAX, S_MIN, S_MIN, 1'b0));
        send_sample(make_sample(-1, 1, -1, 1, 1'b1));
        // half scale phasor: exact halves round up
        load_setup(P_ONE / 2, 0, P_ONE, 0, 1'b0);
        send_sample(make_sample(1, -1, 9, 9, 1'b0));
        send_sample(make_sample(3, -3, -9, -9, 1'b1));
        // one-sample vectors
        send_sample(make_sample(S_MIN, 12345, 1, 1, 1'b1));
        send_sample(make_sample(-12345, S_MAX, 1, 1, 1'b1));
        // step with zero cosine still advances
        load_setup(P_ONE, 0, 0, P_ONE, 1'b0);
        for (int i = 0; i < 4; i++) send_sample(random_sample(i == 3));
    endtask

    task automatic test_random_settings();
        for (int p = 0; p < 10; p++) begin
            if (p == 0) load_setup(P_MAX, P_MAX, P_MAX, P_MAX, 1'b1);
            else if (p == 1) load_setup(P_MIN, P_MIN, P_MIN, P_MIN, 1'b0);
            else load_random_setup();
            send_vectors(100);
        end
    endtask

    task automatic test_back_to_back();
        load_random_setup();
        idle_pct = 0;
        send_vectors(200);
        idle_pct = 37;
    endtask

    task automatic test_output_backpressure();
        load_random_setup();
        hold_requests <= hold_requests + 1;
        send_vectors(80);
    endtask

    task automatic test_drain_pause();
        load_random_setup();
        send_vectors(60);
        wait_all_results();
        send_vectors(60);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_identity_after_reset();
        test_directed_corners();
        test_random_settings();
        test_back_to_back();
        test_output_backpressure();
        test_drain_pause();
        wait_all_results();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("phase_ramp_rotator_top: match");
        end else begin
            $display("phase_ramp_rotator_top: mismatch");
        end
        $finish;
    end

endmodule
